// File: design/htrt_pkg.sv
// ----------------------------------------------------------------------------
// htrt_pkg
// Shared types, character codes and match tables for the raw-text tokenizer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package htrt_pkg;

    // longest tag name that takes part in name matching
    localparam int TAG_NAME_CHARS = 62;
    localparam int NAME_POS_W     = $clog2(TAG_NAME_CHARS + 1);

    // depth of the closer hold buffer
    localparam int HOLD_DEPTH = 8;
    localparam int HOLD_IDX_W = $clog2(HOLD_DEPTH);
    localparam int HOLD_CNT_W = $clog2(HOLD_DEPTH + 2);

    // tokenizer modes
    localparam logic [1:0] MODE_NORMAL = 2'd0;
    localparam logic [1:0] MODE_SCRIPT = 2'd1;
    localparam logic [1:0] MODE_STYLE  = 2'd2;

    // token kinds
    localparam logic KIND_TEXT = 1'b0;
    localparam logic KIND_TAG  = 1'b1;

    // special characters
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;

    // closer lengths
    localparam logic [HOLD_CNT_W-1:0] SCRIPT_CLOSE_LEN = HOLD_CNT_W'(9);
    localparam logic [HOLD_CNT_W-1:0] STYLE_CLOSE_LEN  = HOLD_CNT_W'(8);

    // "</script>" and "</style>"
    localparam logic [7:0] SCRIPT_CLOSE [0:8] = '{
        8'h3C, 8'h2F, 8'h73, 8'h63, 8'h72, 8'h69, 8'h70, 8'h74, 8'h3E
    };
    localparam logic [7:0] STYLE_CLOSE [0:7] = '{
        8'h3C, 8'h2F, 8'h73, 8'h74, 8'h79, 8'h6C, 8'h65, 8'h3E
    };

    // tag names: script, style, /script, /style
    localparam logic [7:0] NAME_TBL [0:3][0:7] = '{
        '{8'h73, 8'h63, 8'h72, 8'h69, 8'h70, 8'h74, 8'h00, 8'h00},
        '{8'h73, 8'h74, 8'h79, 8'h6C, 8'h65, 8'h00, 8'h00, 8'h00},
        '{8'h2F, 8'h73, 8'h63, 8'h72, 8'h69, 8'h70, 8'h74, 8'h00},
        '{8'h2F, 8'h73, 8'h74, 8'h79, 8'h6C, 8'h65, 8'h00, 8'h00}
    };

    // name candidate indexes
    localparam logic [1:0] NAME_SCRIPT     = 2'd0;
    localparam logic [1:0] NAME_STYLE      = 2'd1;
    localparam logic [1:0] NAME_END_SCRIPT = 2'd2;
    localparam logic [1:0] NAME_END_STYLE  = 2'd3;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       is_end;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       token_kind;
        logic       token_first;
        logic [1:0] raw_mode;
        logic       last_of_run;
    } t_out_item;

    // results caused by one item: held bytes first, then an optional tail byte
    typedef struct packed {
        logic [HOLD_DEPTH-1:0][7:0] held;
        logic [HOLD_CNT_W-1:0]      held_cnt;
        logic                       held_kind;
        logic                       held_first;
        logic [1:0]                 held_mode;
        logic                       tail_en;
        logic [7:0]                 tail_byte;
        logic                       tail_kind;
        logic                       tail_first;
        logic [1:0]                 tail_mode;
    } t_burst;

    // ascii upper to lower case
    function automatic logic [7:0] fold_case(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= 8'h41 && c <= 8'h5A) begin
            r = c + 8'd32;
        end
        return r;
    endfunction

    // expected closer character at position k
    function automatic logic [7:0] close_char(input logic is_style,
                                              input logic [HOLD_CNT_W-1:0] k);
        logic [7:0] r;
        r = 8'h00;
        if (is_style) begin
            if (k < STYLE_CLOSE_LEN) begin
                r = STYLE_CLOSE[k[HOLD_IDX_W-1:0]];
            end
        end else if (k < SCRIPT_CLOSE_LEN) begin
            r = SCRIPT_CLOSE[k];
        end
        return r;
    endfunction

    function automatic logic [NAME_POS_W-1:0] name_len(input logic [1:0] j);
        logic [NAME_POS_W-1:0] r;
        unique case (j)
            NAME_SCRIPT:     r = NAME_POS_W'(6);
            NAME_STYLE:      r = NAME_POS_W'(5);
            NAME_END_SCRIPT: r = NAME_POS_W'(7);
            NAME_END_STYLE:  r = NAME_POS_W'(6);
            default:         r = NAME_POS_W'(0);
        endcase
        return r;
    endfunction

endpackage

// File: design/html_tokenizer_raw_text.sv
// ----------------------------------------------------------------------------
// html_tokenizer_raw_text
// Byte-stream tokenizer with script and style raw text handling.
// ----------------------------------------------------------------------------
// Input channel: one document byte per item with an end-of-document flag.
// Output channel: released bytes, each tagged text or tag, with a token-start
// flag, the mode after the byte and a flag on the last result of the item.
// An item is registered in the input register, then the core decides its
// results and loads them into the result register, which drives the output.
// Throughput is one item per cycle for items with zero or one result while
// the output takes each result. An item with more results (up to 9, when
// held closer bytes are released or flushed) holds the result register until
// its last result is taken, and the input stalls behind it.
// Items that are held back as a possible closer give no result and pass at
// full rate even while the result register waits.
// A stall on the output holds the current result; the input register keeps
// its item and the input ready drops until room frees up.
// Synchronous reset empties both registers and returns the tokenizer to
// normal mode at a token start; no result is pending after reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module html_tokenizer_raw_text (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  htrt_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output htrt_pkg::t_out_item o_out_item
);
    import htrt_pkg::*;

    // input register
    logic     r_in_valid;
    t_in_item r_in_item;

    // result register
    logic                  r_b_valid;
    t_burst                r_burst;
    logic [HOLD_CNT_W-1:0] r_idx;

    t_burst                core_burst;
    logic                  core_has_result;
    logic                  step;
    logic                  out_take;
    logic                  b_done;
    logic                  b_free;
    logic [HOLD_CNT_W-1:0] total;
    logic                  cur_held;
    logic                  cur_last;

    htrt_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (r_in_item),
        .i_step       (step),
        .o_burst      (core_burst),
        .o_has_result (core_has_result)
    );

    // result selection
    assign total    = r_burst.held_cnt + HOLD_CNT_W'(r_burst.tail_en);
    assign cur_held = (r_idx < r_burst.held_cnt);
    assign cur_last = (r_idx == total - HOLD_CNT_W'(1));

    always_comb begin
        if (cur_held) begin
            o_out_item.out_byte    = r_burst.held[r_idx[HOLD_IDX_W-1:0]];
            o_out_item.token_kind  = r_burst.held_kind;
            o_out_item.token_first = r_burst.held_first && (r_idx == '0);
            o_out_item.raw_mode    = r_burst.held_mode;
        end else begin
            o_out_item.out_byte    = r_burst.tail_byte;
            o_out_item.token_kind  = r_burst.tail_kind;
            o_out_item.token_first = r_burst.tail_first;
            o_out_item.raw_mode    = r_burst.tail_mode;
        end
        o_out_item.last_of_run = cur_last;
    end

    assign o_out_valid = r_b_valid;

    // flow control
    assign out_take   = r_b_valid && i_out_ready;
    assign b_done     = out_take && cur_last;
    assign b_free     = !r_b_valid || b_done;
    assign step       = r_in_valid && (!core_has_result || b_free);
    assign o_in_ready = !r_in_valid || step;

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_b_valid  <= 1'b0;
            r_idx      <= '0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (step && core_has_result) begin
                r_b_valid <= 1'b1;
                r_idx     <= '0;
            end else if (b_done) begin
                r_b_valid <= 1'b0;
            end else if (out_take) begin
                r_idx     <= r_idx + HOLD_CNT_W'(1);
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_item <= i_in_item;
        end
        if (step && core_has_result) begin
            r_burst <= core_burst;
        end
    end

endmodule

// File: design/htrt_core.sv
// ----------------------------------------------------------------------------
// htrt_core
// Tokenizer state and per-byte decision: holds closer bytes, tracks the tag
// name and describes the results one item causes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module htrt_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  htrt_pkg::t_in_item i_item,
    input  logic              i_step,
    output htrt_pkg::t_burst  o_burst,
    output logic              o_has_result
);
    import htrt_pkg::*;

    // state
    logic [1:0]            r_mode, n_mode;
    logic                  r_inside, n_inside;
    logic                  r_at_start, n_at_start;
    logic [HOLD_CNT_W-1:0] r_held_cnt, n_held_cnt;
    logic [7:0]            r_held [HOLD_DEPTH];
    logic [NAME_POS_W-1:0] r_name_pos, n_name_pos;
    logic [3:0]            r_name_flags, n_name_flags;
    logic                  r_name_fin, n_name_fin;

    // hold buffer write
    logic                  held_we;
    logic [HOLD_IDX_W-1:0] held_widx;

    // item fields
    logic [7:0] c;
    logic [7:0] fc;
    logic       is_end;
    logic       is_ws;

    // name after taking this byte
    logic [NAME_POS_W-1:0] tk_pos;
    logic [3:0]            tk_flags;
    logic                  tk_fin;

    // closer compare
    logic                  is_style;
    logic [HOLD_CNT_W-1:0] close_len;
    logic                  close_hit;

    t_burst b;

    // mode switch from a finished tag name
    function automatic logic [1:0] name_apply(input logic [3:0] flags,
                                              input logic [NAME_POS_W-1:0] pos,
                                              input logic [1:0] mode);
        logic [1:0] r;
        r = mode;
        if (flags[NAME_SCRIPT] && pos == name_len(NAME_SCRIPT)) begin
            r = MODE_SCRIPT;
        end else if (flags[NAME_STYLE] && pos == name_len(NAME_STYLE)) begin
            r = MODE_STYLE;
        end else if ((flags[NAME_END_SCRIPT] && pos == name_len(NAME_END_SCRIPT)) ||
                     (flags[NAME_END_STYLE] && pos == name_len(NAME_END_STYLE))) begin
            r = MODE_NORMAL;
        end
        return r;
    endfunction

    assign c      = i_item.in_byte;
    assign fc     = fold_case(c);
    assign is_end = i_item.is_end;
    assign is_ws  = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);

    // tag name tracking for one more byte
    always_comb begin
        tk_pos   = r_name_pos;
        tk_flags = r_name_flags;
        tk_fin   = r_name_fin;
        if (!r_name_fin) begin
            if (is_ws || r_name_pos >= NAME_POS_W'(TAG_NAME_CHARS)) begin
                tk_fin = 1'b1;
            end else begin
                for (int j = 0; j < 4; j++) begin
                    if (r_name_pos >= name_len(2'(j)) ||
                        fc != NAME_TBL[j][r_name_pos[2:0]]) begin
                        tk_flags[j] = 1'b0;
                    end
                end
                tk_pos = r_name_pos + NAME_POS_W'(1);
            end
        end
    end

    // closer compare against the held prefix
    assign is_style  = (r_mode == MODE_STYLE);
    assign close_len = is_style ? STYLE_CLOSE_LEN : SCRIPT_CLOSE_LEN;
    assign close_hit = (r_held_cnt < close_len) && (fc == close_char(is_style, r_held_cnt));

    // per-item decision
    always_comb begin
        n_mode       = r_mode;
        n_inside     = r_inside;
        n_at_start   = r_at_start;
        n_held_cnt   = r_held_cnt;
        n_name_pos   = r_name_pos;
        n_name_flags = r_name_flags;
        n_name_fin   = r_name_fin;
        held_we      = 1'b0;
        held_widx    = '0;

        b            = '0;
        for (int i = 0; i < HOLD_DEPTH; i++) begin
            b.held[i] = r_held[i];
        end
        // snapshot carries this byte at the next free slot
        if (r_held_cnt < HOLD_CNT_W'(HOLD_DEPTH)) begin
            b.held[r_held_cnt[HOLD_IDX_W-1:0]] = c;
        end
        b.held_mode = r_mode;
        b.tail_byte = c;
        b.tail_mode = r_mode;

        if (r_inside) begin
            // inside a tag: runs through '>'
            if (c != CH_GT) begin
                n_name_pos   = tk_pos;
                n_name_flags = tk_flags;
                n_name_fin   = tk_fin;
            end
            if (c == CH_GT || is_end) begin
                n_mode     = name_apply(n_name_flags, n_name_pos, r_mode);
                n_inside   = 1'b0;
                n_at_start = 1'b1;
            end
            b.tail_en   = 1'b1;
            b.tail_kind = KIND_TAG;
            b.tail_mode = n_mode;
        end else if (r_held_cnt != '0) begin
            if (close_hit) begin
                if (r_held_cnt + HOLD_CNT_W'(1) == close_len) begin
                    // full closer: release held bytes as a tag
                    b.held_cnt   = r_held_cnt;
                    b.held_kind  = KIND_TAG;
                    b.held_first = 1'b1;
                    n_held_cnt   = '0;
                    n_mode       = MODE_NORMAL;
                    n_at_start   = 1'b1;
                    n_name_pos   = '0;
                    n_name_flags = 4'hF;
                    n_name_fin   = 1'b0;
                    b.tail_en    = 1'b1;
                    b.tail_kind  = KIND_TAG;
                    b.tail_mode  = MODE_NORMAL;
                end else begin
                    // closer still possible: hold this byte too
                    held_we    = 1'b1;
                    held_widx  = r_held_cnt[HOLD_IDX_W-1:0];
                    n_held_cnt = r_held_cnt + HOLD_CNT_W'(1);
                    if (is_end) begin
                        b.held_cnt = n_held_cnt;
                    end
                end
            end else begin
                // mismatch: flush held bytes as text
                b.held_cnt = r_held_cnt;
                n_held_cnt = '0;
                if (c == CH_LT) begin
                    held_we    = 1'b1;
                    n_held_cnt = HOLD_CNT_W'(1);
                    b.tail_en  = is_end;
                end else begin
                    b.tail_en  = 1'b1;
                end
            end
        end else if (c == CH_LT && (r_at_start || r_mode == MODE_NORMAL)) begin
            // tag opens; a cleared name changes no mode
            n_inside     = 1'b1;
            n_at_start   = 1'b0;
            n_name_pos   = '0;
            n_name_flags = 4'hF;
            n_name_fin   = 1'b0;
            b.tail_en    = 1'b1;
            b.tail_kind  = KIND_TAG;
            b.tail_first = 1'b1;
        end else begin
            // text byte, or a possible closer start in raw mode
            n_at_start = 1'b0;
            if (c == CH_LT) begin
                held_we    = 1'b1;
                n_held_cnt = HOLD_CNT_W'(1);
                b.tail_en  = is_end;
            end else begin
                b.tail_en    = 1'b1;
                b.tail_first = r_at_start;
            end
        end

        // end of document: everything back to reset
        if (is_end) begin
            n_mode       = MODE_NORMAL;
            n_inside     = 1'b0;
            n_at_start   = 1'b1;
            n_held_cnt   = '0;
            n_name_pos   = '0;
            n_name_flags = 4'hF;
            n_name_fin   = 1'b0;
        end
    end

    assign o_burst      = b;
    assign o_has_result = (b.held_cnt != '0) || b.tail_en;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= MODE_NORMAL;
            r_inside     <= 1'b0;
            r_at_start   <= 1'b1;
            r_held_cnt   <= '0;
            r_name_pos   <= '0;
            r_name_flags <= 4'hF;
            r_name_fin   <= 1'b0;
        end else if (i_step) begin
            r_mode       <= n_mode;
            r_inside     <= n_inside;
            r_at_start   <= n_at_start;
            r_held_cnt   <= n_held_cnt;
            r_name_pos   <= n_name_pos;
            r_name_flags <= n_name_flags;
            r_name_fin   <= n_name_fin;
        end
    end

    // hold buffer, no reset
    always_ff @(posedge i_clk) begin
        if (i_step && held_we) begin
            r_held[held_widx] <= c;
        end
    end

endmodule

// File: design/htrt_checker.sv
// ----------------------------------------------------------------------------
// htrt_checker
// Port-level checks for the raw-text tokenizer, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module htrt_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_ready,
    input htrt_pkg::t_in_item  i_in_item,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input htrt_pkg::t_out_item o_out_item
);
    import htrt_pkg::*;

    // nothing pending right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // waiting input item holds
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_ready |=> i_in_valid && $stable(i_in_item))
        else $error("waiting input item changed");

    // stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error("stalled result changed");

    // a run continues in the next cycle until its last result
    a_run_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && !o_out_item.last_of_run |=> o_out_valid)
        else $error("run of results broken");

    // a tag token starts with '<'
    a_tag_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.token_kind == KIND_TAG && o_out_item.token_first
        |-> o_out_item.out_byte == CH_LT)
        else $error("tag token does not start with '<'");

endmodule

bind html_tokenizer_raw_text htrt_checker u_htrt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_item   (i_in_item),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_item  (o_out_item)
);

// File: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for html_tokenizer_raw_text. Document bytes are fed
// as directed strings and random documents (tags, raw text, partial and
// complete closers, noise). A behavioral tokenizer predicts the released
// bytes of every accepted item, and a monitor checks each released item in
// order while both channels idle at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
    import htrt_pkg::*;

    localparam logic [7:0] CH_SLASH = 8'h2F;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    t_in_item  in_item = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_item out_item;

    // idling controls, percent of items or cycles
    int gap_pct = 0;
    int stall_pct = 0;
    int stall_left = 0;
    int fault_count = 0;

    // predicted tokenizer state
    logic [1:0] tk_mode;
    logic       tk_in_tag;
    logic       tk_at_start;
    int         tk_held_cnt;
    logic [7:0] tk_held [8];
    int         nm_pos;
    logic [3:0] nm_flags;
    logic       nm_done;

    // released bytes of the item being predicted, and bytes still due
    t_out_item  run_buf [10];
    int         run_len;
    t_out_item  due_bytes [$];

    // document under construction
    logic [7:0] doc_q [$];

    html_tokenizer_raw_text u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item)
    );

    // clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // behavioral tokenizer
    // ------------------------------------------------------------------

    function automatic logic [7:0] lower(input logic [7:0] c);
        if (c >= 8'h41 && c <= 8'h5A) begin
            return c + 8'd32;
        end
        return c;
    endfunction

    function automatic string cand_name(input int j);
        string s;
        case (j)
            NAME_SCRIPT:     s = "script";
            NAME_STYLE:      s = "style";
            NAME_END_SCRIPT: s = "/script";
            default:         s = "/style";
        endcase
        return s;
    endfunction

    function automatic string closer_text(input logic [1:0] m);
        string s;
        if (m == MODE_STYLE) begin
            s = "</style>";
        end else begin
            s = "</script>";
        end
        return s;
    endfunction

    function automatic logic name_hit(input int j);
        string s;
        s = cand_name(j);
        return nm_flags[j] && (nm_pos == s.len());
    endfunction

    function automatic void clear_name();
        nm_pos = 0;
        nm_flags = 4'hF;
        nm_done = 1'b0;
    endfunction

    // tag name decides the mode
    function automatic void apply_name();
        if (name_hit(NAME_SCRIPT)) begin
            tk_mode = MODE_SCRIPT;
        end else if (name_hit(NAME_STYLE)) begin
            tk_mode = MODE_STYLE;
        end else if (name_hit(NAME_END_SCRIPT) || name_hit(NAME_END_STYLE)) begin
            tk_mode = MODE_NORMAL;
        end
    endfunction

    function automatic void reset_tokenizer();
        tk_mode = MODE_NORMAL;
        tk_in_tag = 1'b0;
        tk_at_start = 1'b1;
        tk_held_cnt = 0;
        clear_name();
    endfunction

    function automatic void release_byte(input logic [7:0] b, input logic kind,
                                         input logic first);
        run_buf[run_len] = '{out_byte: b, token_kind: kind, token_first: first,
                             raw_mode: tk_mode, last_of_run: 1'b0};
        run_len++;
    endfunction

    function automatic void flush_held();
        for (int i = 0; i < tk_held_cnt; i++) begin
            release_byte(tk_held[i], KIND_TEXT, 1'b0);
        end
        tk_held_cnt = 0;
    endfunction

    // one document byte in, its released bytes appended to due_bytes
    function automatic void tokenize_byte(input logic [7:0] c, input logic last_byte);
        string s;
        int k;
        logic first;
        run_len = 0;
        if (tk_in_tag) begin
            // name collection inside a tag
            if (c != CH_GT && !nm_done) begin
                if (c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF) begin
                    nm_done = 1'b1;
                end else if (nm_pos >= TAG_NAME_CHARS) begin
                    nm_done = 1'b1;
                end else begin
                    for (int j = 0; j < 4; j++) begin
                        s = cand_name(j);
                        if (nm_pos >= s.len() || lower(c) != s[nm_pos]) begin
                            nm_flags[j] = 1'b0;
                        end
                    end
                    nm_pos++;
                end
            end
            if (c == CH_GT || last_byte) begin
                apply_name();
                tk_in_tag = 1'b0;
                tk_at_start = 1'b1;
            end
            release_byte(c, KIND_TAG, 1'b0);
        end else if (tk_held_cnt > 0) begin
            // possible closer in progress
            s = closer_text(tk_mode);
            k = tk_held_cnt;
            if (k < s.len() && lower(c) == s[k]) begin
                if (k + 1 == s.len()) begin
                    for (int i = 0; i < k; i++) begin
                        release_byte(tk_held[i], KIND_TAG, i == 0);
                    end
                    tk_held_cnt = 0;
                    tk_mode = MODE_NORMAL;
                    tk_at_start = 1'b1;
                    clear_name();
                    release_byte(c, KIND_TAG, 1'b0);
                end else if (k < 8) begin
                    tk_held[k] = c;
                    tk_held_cnt = k + 1;
                end
            end else begin
                flush_held();
                if (c == CH_LT) begin
                    tk_held[0] = c;
                    tk_held_cnt = 1;
                end else begin
                    release_byte(c, KIND_TEXT, 1'b0);
                end
            end
        end else if (c == CH_LT && (tk_at_start || tk_mode == MODE_NORMAL)) begin
            // tag opens
            tk_in_tag = 1'b1;
            tk_at_start = 1'b0;
            clear_name();
            if (last_byte) begin
                apply_name();
                tk_in_tag = 1'b0;
                tk_at_start = 1'b1;
            end
            release_byte(c, KIND_TAG, 1'b1);
        end else begin
            // text, or the start of a possible closer
            first = tk_at_start;
            tk_at_start = 1'b0;
            if (c == CH_LT) begin
                tk_held[0] = c;
                tk_held_cnt = 1;
            end else begin
                release_byte(c, KIND_TEXT, first);
            end
        end
        if (last_byte) begin
            flush_held();
            reset_tokenizer();
        end
        if (run_len > 0) begin
            run_buf[run_len - 1].last_of_run = 1'b1;
        end
        for (int i = 0; i < run_len; i++) begin
            due_bytes.push_back(run_buf[i]);
        end
    endfunction

    // ------------------------------------------------------------------
    // output side: random stalls and result check
    // ------------------------------------------------------------------

    // ready pattern, mostly short stalls with a few long ones
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
        end else if ($urandom_range(0, 99) < stall_pct) begin
            out_ready <= 1'b0;
            stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                       : $urandom_range(0, 2);
        end else begin
            out_ready <= 1'b1;
            stall_left <= $urandom_range(0, 4);
        end
    end

    // compare each released item with the oldest prediction
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && out_valid && out_ready) begin
            if (due_bytes.size() == 0) begin
                $display("%0t: unexpected item: byte %h kind %0d first %0d mode %0d last %0d",
                         $time, out_item.out_byte, out_item.token_kind,
                         out_item.token_first, out_item.raw_mode, out_item.last_of_run);
                fault_count++;
            end else begin
                want = due_bytes.pop_front();
                if (out_item !== want) begin
                    $display({"%0t: mismatch: expected byte %h kind %0d first %0d",
                              " mode %0d last %0d, actual byte %h kind %0d",
                              " first %0d mode %0d last %0d"},
                             $time, want.out_byte, want.token_kind, want.token_first,
                             want.raw_mode, want.last_of_run, out_item.out_byte,
                             out_item.token_kind, out_item.token_first,
                             out_item.raw_mode, out_item.last_of_run);
                    fault_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // input side
    // ------------------------------------------------------------------

    // send one document byte, predict once it is accepted
    task automatic feed_byte(input logic [7:0] c, input logic last_byte);
        int gap;
        gap = 0;
        if ($urandom_range(0, 99) < gap_pct) begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 3);
        end
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_item <= '{in_byte: c, is_end: last_byte};
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
        tokenize_byte(c, last_byte);
    endtask

    task automatic feed_text(input string s, input logic end_last);
        for (int i = 0; i < s.len(); i++) begin
            feed_byte(s[i], end_last && (i == s.len() - 1));
        end
    endtask

    task automatic feed_document();
        for (int i = 0; i < doc_q.size(); i++) begin
            feed_byte(doc_q[i], i == doc_q.size() - 1);
        end
    endtask

    function automatic logic [7:0] mix_case(input logic [7:0] c);
        if (c >= 8'h61 && c <= 8'h7A && $urandom_range(0, 1) == 1) begin
            return c - 8'd32;
        end
        return c;
    endfunction

    function automatic logic [7:0] rand_letter();
        return mix_case(8'h61 + 8'($urandom_range(0, 25)));
    endfunction

    // random document made of text, tags, closers and noise
    function automatic void build_document(input int target);
        string nm;
        logic [7:0] c;
        int cut;
        doc_q.delete();
        while (doc_q.size() < target) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: begin
                    // plain text
                    repeat ($urandom_range(1, 6)) begin
                        c = 8'($urandom_range(1, 255));
                        doc_q.push_back((c == CH_LT) ? CH_GT : c);
                    end
                end
                4, 5, 6: begin
                    // tag with a name of interest or a random one
                    doc_q.push_back(CH_LT);
                    case ($urandom_range(0, 5))
                        0:       nm = "script";
                        1:       nm = "style";
                        2:       nm = "/script";
                        3:       nm = "/style";
                        4:       nm = "scripts";
                        default: nm = "";
                    endcase
                    if (nm.len() == 0) begin
                        repeat ($urandom_range(1, 8)) doc_q.push_back(rand_letter());
                    end else begin
                        for (int i = 0; i < nm.len(); i++) doc_q.push_back(mix_case(nm[i]));
                    end
                    if ($urandom_range(0, 2) == 0) begin
                        case ($urandom_range(0, 3))
                            0:       doc_q.push_back(CH_SPACE);
                            1:       doc_q.push_back(CH_TAB);
                            2:       doc_q.push_back(CH_CR);
                            default: doc_q.push_back(CH_LF);
                        endcase
                        repeat ($urandom_range(0, 4)) begin
                            c = 8'($urandom_range(1, 255));
                            doc_q.push_back((c == CH_GT) ? CH_SLASH : c);
                        end
                    end
                    if ($urandom_range(0, 9) != 0) begin
                        doc_q.push_back(CH_GT);
                    end
                end
                7, 8: begin
                    // closer, sometimes cut short or broken
                    if ($urandom_range(0, 1) == 1) begin
                        nm = "</script>";
                    end else begin
                        nm = "</style>";
                    end
                    cut = ($urandom_range(0, 2) == 0) ? $urandom_range(1, nm.len() - 1)
                                                      : nm.len();
                    for (int i = 0; i < cut; i++) doc_q.push_back(mix_case(nm[i]));
                    if (cut < nm.len() && $urandom_range(0, 1) == 1) begin
                        doc_q.push_back(8'($urandom_range(1, 255)));
                    end
                end
                default: begin
                    // noise around the special characters
                    repeat ($urandom_range(1, 3)) begin
                        case ($urandom_range(0, 3))
                            0:       doc_q.push_back(CH_LT);
                            1:       doc_q.push_back(CH_GT);
                            2:       doc_q.push_back(CH_SLASH);
                            default: doc_q.push_back(8'($urandom_range(1, 255)));
                        endcase
                    end
                end
            endcase
        end
    endfunction

    // stop feeding and wait for every predicted item
    task automatic settle_outputs();
        in_valid <= 1'b0;
        while (due_bytes.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // lowest nonzero and highest byte values, second one ends the document
    task automatic test_byte_extremes();
        feed_byte(8'h01, 1'b0);
        feed_byte(8'hFF, 1'b1);
    endtask

    // style raw text with a broken closer, a doubled '<' and a mixed-case closer
    task automatic test_style_closer();
        feed_text("<StYle>a</x<</STYLE>", 1'b1);
    endtask

    // tag cut off by end of input still switches the mode on its last byte
    task automatic test_tag_at_end();
        feed_text("<style", 1'b1);
    endtask

    // tag name longer than the matched length
    task automatic test_long_tag_name();
        doc_q.delete();
        doc_q.push_back(CH_LT);
        repeat (TAG_NAME_CHARS + 1) doc_q.push_back(rand_letter());
        doc_q.push_back(CH_SPACE);
        doc_q.push_back(CH_GT);
        doc_q.push_back(8'h61);
        feed_document();
    endtask

    // random documents under three idling levels
    task automatic test_random_documents();
        int fed;
        for (int phase = 0; phase < 3; phase++) begin
            gap_pct = phase * 30;
            stall_pct = phase * 30;
            fed = 0;
            while (fed < 45) begin
                build_document(($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 30));
                feed_document();
                fed += doc_q.size();
            end
        end
    endtask

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------

    initial begin
        reset_tokenizer();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        gap_pct = 20;
        stall_pct = 20;
        test_byte_extremes();
        test_style_closer();
        test_tag_at_end();
        test_long_tag_name();
        test_random_documents();
        settle_outputs();
        if (fault_count == 0) begin
            $display("html_tokenizer_raw_text verification clean");
        end else begin
            $display("html_tokenizer_raw_text verification failed");
        end
        $finish;
    end

    // run limit
    initial begin
        #10_000_000;
        $display("html_tokenizer_raw_text verification failed");
        $finish;
    end

endmodule

// File: sim.f
design/htrt_pkg.sv
design/htrt_core.sv
design/html_tokenizer_raw_text.sv
design/htrt_checker.sv
tb/sv/testbench.sv
